>>> design/tlbs_pkg.sv
// ----------------------------------------------------------------------------
// tlbs_pkg: shared types and microprogram for the key table search core
// Control word layout, step numbers, register indexes and the program ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbs_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_METHOD = 8'd1;

  localparam int COUNT_W = 11;
  localparam int ADDR_IN_W = 10;
  localparam int POS_W = 10;
  localparam int KEY_W = 32;

  // Microprogram step numbers
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] STEP_INIT = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LSCAN = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RESP = 3'd3;
  localparam logic [STEP_W-1:0] STEP_BTEST = 3'd4;
  localparam logic [STEP_W-1:0] STEP_BSTEP = 3'd5;
  localparam logic [STEP_W-1:0] STEP_BFIN = 3'd6;
  localparam logic [STEP_W-1:0] STEP_BCHK = 3'd7;

  // Datapath actions
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_INIT  = 3'd1,  // lo to 0, hi to count; latch count
    ACT_LSCAN = 3'd2,  // read idx, compare previous read
    ACT_BMID  = 3'd3,  // form midpoint, read it
    ACT_BSTEP = 3'd4,  // narrow lo/hi from midpoint data
    ACT_BREAD = 3'd5,  // read entry at lo
    ACT_BCHK  = 3'd6,  // final compare at lo
    ACT_RESP  = 3'd7   // present result
  } act_t;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_METHOD   = 3'd2,
    COND_LIN_MORE = 3'd3,
    COND_LO_GE_HI = 3'd4
  } cond_t;

  typedef struct packed {
    act_t              act;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Program ROM: jump to target when cond holds, else fall through.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] s);
    ctrl_word_t w;
    w = '{act: ACT_NONE, cond: COND_NEXT, target: STEP_IDLE};
    case (s)
      STEP_IDLE:  w = '{act: ACT_NONE,  cond: COND_NEXT,     target: STEP_IDLE};
      STEP_INIT:  w = '{act: ACT_INIT,  cond: COND_METHOD,   target: STEP_BTEST};
      STEP_LSCAN: w = '{act: ACT_LSCAN, cond: COND_LIN_MORE, target: STEP_LSCAN};
      STEP_RESP:  w = '{act: ACT_RESP,  cond: COND_ALWAYS,   target: STEP_IDLE};
      STEP_BTEST: w = '{act: ACT_BMID,  cond: COND_LO_GE_HI, target: STEP_BFIN};
      STEP_BSTEP: w = '{act: ACT_BSTEP, cond: COND_ALWAYS,   target: STEP_BTEST};
      STEP_BFIN:  w = '{act: ACT_BREAD, cond: COND_NEXT,     target: STEP_IDLE};
      STEP_BCHK:  w = '{act: ACT_BCHK,  cond: COND_ALWAYS,   target: STEP_RESP};
      default:    w = '{act: ACT_NONE,  cond: COND_ALWAYS,   target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/table_linear_binary_search_core.sv
// ----------------------------------------------------------------------------
// table_linear_binary_search_core: searchable key table
// Table of signed 32-bit keys with load, linear scan and lower-bound search.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken when start is high and busy is
// low, and busy stays high until its result has been shown. Every request
// gives exactly one result, held on found/position/load_done for the single
// cycle in which done is high; the receiver cannot stall it, so sample it
// then. A load is accepted, then its result is shown in the RESP step. A
// linear search reads one table entry per cycle from the key memory and
// stops at the first match or after n entries, n being the searched count
// (entry_count capped at TABLE_DEPTH). A binary search reads the midpoint
// (BTEST) and narrows lo/hi (BSTEP) per halving, then reads and compares
// the entry at lo (BFIN, BCHK). The user must write registers on the cfg
// channel (cfg_ready is always high) while the core is idle (unenforced).
// Entries never loaded read back as garbage; searches must not reach them.
// ----------------------------------------------------------------------------
`default_nettype none

module table_linear_binary_search_core
  import tlbs_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  mode,
  input  wire logic [ADDR_IN_W-1:0]  address,
  input  wire logic signed [KEY_W-1:0] value,
  // result
  output logic                       done,
  output logic                       found,
  output logic [POS_W-1:0]           position,
  output logic                       load_done,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // memory index width, and a counter width that holds the depth itself
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = (DW > COUNT_W) ? DW : COUNT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // configuration
  logic [COUNT_W-1:0] entry_count;
  logic               search_method;

  // sequencer
  logic [STEP_W-1:0] step, step_next;
  ctrl_word_t        cw;
  logic              jump;

  // datapath
  logic [CW-1:0]           lo, hi, idx, pidx, n_cnt;
  logic                    pv;
  logic signed [KEY_W-1:0] key;
  logic signed [KEY_W-1:0] rd_data;
  logic                    res_found, res_load;
  logic [CW-1:0]           res_pos;

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             mem_we;

  logic          accept;
  logic [CW-1:0] ec_ext, n_valid, addr_ext, mid;
  logic          lin_hit;

  assign accept    = start && !busy;
  assign busy      = (step != STEP_IDLE);
  assign cfg_ready = 1'b1;

  // count capped at depth
  assign ec_ext  = CW'(entry_count);
  assign n_valid = (ec_ext > DEPTH_C) ? DEPTH_C : ec_ext;

  assign addr_ext = CW'(address);
  assign wr_addr  = addr_ext[AW-1:0];
  assign mem_we   = accept && !mode && (addr_ext < DEPTH_C);

  assign mid     = lo + ((hi - lo) >> 1);
  assign lin_hit = pv && (rd_data == key);

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      search_method <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENTRY_COUNT:   entry_count   <= cfg_data[COUNT_W-1:0];
        REG_SEARCH_METHOD: search_method <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- microprogram sequencer ----
  assign cw = ucode(step);

  always_comb begin
    case (cw.cond)
      COND_NEXT:     jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_METHOD:   jump = search_method;
      COND_LIN_MORE: jump = !lin_hit && (idx < n_cnt);
      COND_LO_GE_HI: jump = (lo >= hi);
      default:       jump = 1'b1;
    endcase
  end

  always_comb begin
    if (step == STEP_IDLE) begin
      // dispatch: loads finish at once, searches run the program
      if (accept) begin
        step_next = mode ? STEP_INIT : STEP_RESP;
      end else begin
        step_next = STEP_IDLE;
      end
    end else if (jump) begin
      step_next = cw.target;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // ---- read address select ----
  always_comb begin
    case (cw.act)
      ACT_LSCAN: rd_addr = idx[AW-1:0];
      ACT_BMID:  rd_addr = mid[AW-1:0];
      ACT_BREAD: rd_addr = lo[AW-1:0];
      default:   rd_addr = idx[AW-1:0];
    endcase
  end

  // ---- key memory, registered read ----
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[wr_addr] <= value;
    end
    rd_data <= key_mem[rd_addr];
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      if (accept) begin
        key       <= value;
        res_found <= 1'b0;
        res_pos   <= '0;
        res_load  <= !mode;
      end
      case (cw.act)
        ACT_INIT: begin
          lo    <= '0;
          hi    <= n_valid;
          n_cnt <= n_valid;
          idx   <= '0;
          pv    <= 1'b0;
        end
        ACT_LSCAN: begin
          // compare last read while issuing the next one
          if (lin_hit) begin
            res_found <= 1'b1;
            res_pos   <= pidx;
          end
          pv   <= (idx < n_cnt);
          pidx <= idx;
          idx  <= idx + CW'(1);
        end
        ACT_BMID: begin
          idx <= mid;
        end
        ACT_BSTEP: begin
          if (rd_data < key) begin
            lo <= idx + CW'(1);
          end else begin
            hi <= idx;
          end
        end
        ACT_BCHK: begin
          if ((lo < n_cnt) && (rd_data == key)) begin
            res_found <= 1'b1;
            res_pos   <= lo;
          end
        end
        default: ;
      endcase
    end
  end

  // ---- result ports ----
  assign done      = (step == STEP_RESP);
  assign found     = res_found;
  assign position  = res_pos[POS_W-1:0];
  assign load_done = res_load;

  // ---- assertions ----
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but core not busy");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (done && load_done) |-> (!found && (position == '0)))
    else $error("load result carries search data");

  a_bin_bounds: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_BSTEP) |-> ((lo < hi) && (idx >= lo) && (idx < hi)))
    else $error("binary search midpoint outside bounds");

  a_lin_count: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_LSCAN) |-> (idx <= n_cnt))
    else $error("linear scan index past searched count");

endmodule

`default_nettype wire
